// ===== rtl/hash_map_engine_defines.svh =====
// Assertion macros for the hash map engine.
`ifndef HASH_MAP_ENGINE_DEFINES_SVH
`define HASH_MAP_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hme_pkg.sv =====
package hme_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [1:0] status_t;

    // Request operations
    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_LOOKUP = 2'd2;
    localparam kind_t KIND_CLEAR  = 2'd3;

    // Result codes
    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_DUP  = 2'd1;
    localparam status_t STATUS_MISS = 2'd2;
    localparam status_t STATUS_FULL = 2'd3;

    localparam int VALUE_W = 32;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 9;

endpackage

// ===== rtl/hash_map_engine.sv =====
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+---------------------
// request   | s_kind, s_key, s_value                       | s_valid / s_ready
// result    | m_status, m_found_value, m_entry_count       | m_valid / m_ready
//
// One request is in flight at a time. With a power-of-two BUCKETS a request
// is accepted and its row read, then compared and its row written back.
// Otherwise the bucket index is formed first in S_HASH and S_MOD: a reciprocal
// multiply of the key gives the quotient, then quotient times BUCKETS is subtracted.
// Clear all sweeps the bucket memory one row a cycle, then reports its result.
// After reset the same sweep runs with s_ready low.
// A full result register stalls the update step only; a waiting result
// does not block acceptance of the next request.
`include "hash_map_engine_defines.svh"

module hash_map_engine #(
    parameter int BUCKETS  = 64,
    parameter int WAYS     = 4,
    parameter int KEY_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hme_pkg::kind_t                s_kind,
    input  logic [hme_pkg::KEY_W-1:0]     s_key,
    input  logic signed [hme_pkg::VALUE_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hme_pkg::status_t              m_status,
    output logic signed [hme_pkg::VALUE_W-1:0] m_found_value,
    output logic [hme_pkg::COUNT_W-1:0]   m_entry_count
);

    localparam int KW      = (KEY_BITS < hme_pkg::KEY_W) ? KEY_BITS : hme_pkg::KEY_W;
    localparam int VW      = hme_pkg::VALUE_W;
    localparam int BW      = $clog2(BUCKETS);
    localparam int SLOTS   = BUCKETS * WAYS;
    localparam int CW      = $clog2(SLOTS + 1);
    localparam int ENTRY_W = 1 + KW + VW;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam bit POW2    = ((BUCKETS & (BUCKETS - 1)) == 0);

    // Reciprocal of BUCKETS, rounded up, exact for every KW-bit key
    localparam int MSH = KW + BW;
    localparam int PW  = 2 * KW + 1;
    localparam int QW  = KW + BW;
    localparam logic [63:0] MOD_M =
        ((64'd1 << MSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    // Bucket memory: one row holds all ways of a bucket
    logic [ROW_W-1:0] mem [BUCKETS];
    logic [ROW_W-1:0] rdata_reg;

    logic [2:0]       state_reg, state_next;
    logic [BW-1:0]    sweep_reg, sweep_next;
    logic             clr_op_reg, clr_op_next;
    logic [KW-1:0]    quot_reg, quot_next;
    logic [BW-1:0]    bucket_reg;
    hme_pkg::kind_t   kind_reg;
    logic [KW-1:0]    key_reg;
    logic [VW-1:0]    value_reg;
    logic [CW-1:0]    count_reg, count_next;

    logic             out_valid_reg;
    hme_pkg::status_t status_reg, status_next;
    logic [VW-1:0]    found_reg, found_next;
    logic [hme_pkg::COUNT_W-1:0] ecount_reg, ecount_next;

    logic             in_accept;
    logic             out_free;
    logic             out_load;
    logic             rd_en;
    logic [BW-1:0]    rd_addr;
    logic             mem_we;
    logic [BW-1:0]    waddr;
    logic [ROW_W-1:0] wdata;

    logic [KW-1:0]    key_in;
    logic [31:0]      key_in_wide;
    logic [BW-1:0]    idx_in;
    logic [PW-1:0]    mod_prod;
    logic [QW-1:0]    mod_back;
    logic [QW-1:0]    mod_diff;
    logic [BW-1:0]    idx_mod;

    logic [WAYS-1:0]  way_valid;
    logic [WAYS-1:0]  way_hit;
    logic [VW-1:0]    hit_value;
    logic             any_hit;
    logic             free_found;
    logic [WAYS-1:0]  free_sel;
    logic [ROW_W-1:0] row_upd;
    logic [31:0]      count_wide;

    logic             clr_accept;
    logic             sweep_start;
    logic             we_legal;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || m_ready;

    // Masked key and its bucket when the bucket count is a power of two
    assign key_in      = s_key[KW-1:0];
    assign key_in_wide = 32'(key_in);
    assign idx_in      = key_in_wide[BW-1:0];

    // Bucket for other counts: quotient by reciprocal multiply, then subtract back
    assign mod_prod = PW'(key_reg) * PW'(MOD_M[KW:0]);
    assign mod_back = QW'(quot_reg) * QW'(BUCKETS);
    assign mod_diff = QW'(key_reg) - mod_back;
    assign idx_mod  = mod_diff[BW-1:0];

    // Compare the read row against the request key
    always_comb begin
        logic [ENTRY_W-1:0] ent;
        way_valid  = '0;
        way_hit    = '0;
        hit_value  = '0;
        for (int w = 0; w < WAYS; w++) begin
            ent          = rdata_reg[w*ENTRY_W +: ENTRY_W];
            way_valid[w] = ent[ENTRY_W-1];
            way_hit[w]   = ent[ENTRY_W-1] && (ent[VW +: KW] == key_reg);
            if (way_hit[w]) begin
                hit_value = ent[VW-1:0];
            end
        end
        any_hit = |way_hit;
    end

    // Pick the lowest free way
    always_comb begin
        free_found = 1'b0;
        free_sel   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!way_valid[w] && !free_found) begin
                free_sel[w] = 1'b1;
                free_found  = 1'b1;
            end
        end
    end

    // Build the written-back row
    always_comb begin
        row_upd = rdata_reg;
        for (int w = 0; w < WAYS; w++) begin
            if (kind_reg == hme_pkg::KIND_INSERT && free_sel[w]) begin
                row_upd[w*ENTRY_W +: ENTRY_W] = {1'b1, key_reg, value_reg};
            end else if (kind_reg == hme_pkg::KIND_REMOVE && way_hit[w]) begin
                row_upd[w*ENTRY_W + ENTRY_W - 1] = 1'b0;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        clr_op_next = clr_op_reg;
        quot_next   = quot_reg;
        count_next  = count_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_in;
        mem_we      = 1'b0;
        waddr       = bucket_reg;
        wdata       = row_upd;
        out_load    = 1'b0;
        status_next = hme_pkg::STATUS_OK;
        found_next  = '0;
        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                waddr  = sweep_reg;
                wdata  = '0;
                if (sweep_reg == BW'(BUCKETS - 1)) begin
                    state_next = clr_op_reg ? S_EXEC : S_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_kind == hme_pkg::KIND_CLEAR) begin
                        state_next  = S_CLEAR;
                        sweep_next  = '0;
                        clr_op_next = 1'b1;
                    end else if (POW2) begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_in;
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                quot_next  = KW'(mod_prod >> MSH);
                state_next = S_MOD;
            end
            S_MOD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_mod;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (clr_op_reg) begin
                        clr_op_next = 1'b0;
                        count_next  = '0;
                    end else begin
                        case (kind_reg)
                            hme_pkg::KIND_INSERT: begin
                                if (any_hit) begin
                                    status_next = hme_pkg::STATUS_DUP;
                                end else if (!free_found) begin
                                    status_next = hme_pkg::STATUS_FULL;
                                end else begin
                                    mem_we     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            hme_pkg::KIND_REMOVE: begin
                                if (any_hit) begin
                                    mem_we = 1'b1;
                                    if (count_reg != '0) begin
                                        count_next = count_reg - 1'b1;
                                    end
                                end else begin
                                    status_next = hme_pkg::STATUS_MISS;
                                end
                            end
                            hme_pkg::KIND_LOOKUP: begin
                                if (any_hit) begin
                                    found_next = hit_value;
                                end else begin
                                    status_next = hme_pkg::STATUS_MISS;
                                end
                            end
                            default: begin
                                count_next = '0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entry count reported modulo 512
    assign count_wide  = 32'(count_next);
    assign ecount_next = count_wide[hme_pkg::COUNT_W-1:0];

    // Bucket memory ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            clr_op_reg    <= 1'b0;
            quot_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            clr_op_reg <= clr_op_next;
            quot_reg   <= quot_next;
            count_reg  <= count_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg  <= s_kind;
            key_reg   <= key_in;
            value_reg <= s_value;
        end
        if (rd_en) begin
            bucket_reg <= rd_addr;
        end
        if (out_load) begin
            status_reg <= status_next;
            found_reg  <= found_next;
            ecount_reg <= ecount_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = status_reg;
    assign m_found_value = found_reg;
    assign m_entry_count = ecount_reg;

    assign clr_accept  = in_accept && (s_kind == hme_pkg::KIND_CLEAR);
    assign sweep_start = (state_reg == S_CLEAR) && (sweep_reg == '0);
    assign we_legal    = (state_reg == S_EXEC) || (state_reg == S_CLEAR);

    `HME_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(SLOTS), "live count above slot total")
    `HME_ASSERT_IMP(a_we_state, mem_we, we_legal, "stray memory write")
    `HME_ASSERT_NXT(a_count_hold, !out_load, $stable(count_reg), "count moved without a result")
    `HME_ASSERT_NXT(a_clear_sweep, clr_accept, sweep_start, "clear did not start sweep")

endmodule
